### rtl/cnms_pkg.sv
// Shared constants, types and the state encoding of the non-maximum suppression core.
// Used by every file under rtl; depends on nothing else.
package cnms_pkg;

    localparam int MAX_WIDTH   = 2048;
    localparam int MAX_HEIGHT  = 2048;
    localparam int GRAD_BITS   = 16;
    localparam int ADDR_BITS   = $clog2(MAX_WIDTH);
    localparam int MAG_BITS    = 16;
    localparam int DIR_BITS    = 2;
    localparam int POS_BITS    = 11;
    localparam int DIM_BITS    = 12;
    localparam int ABS_BITS    = GRAD_BITS + 1;
    localparam int SQ_BITS     = 2 * GRAD_BITS;
    localparam int LINE_BITS   = 2 * MAG_BITS + DIR_BITS;
    localparam int ROOT_STEPS  = SQ_BITS / 2;
    localparam int STEP_BITS   = $clog2(ROOT_STEPS);
    localparam int IN_BYTES_W  = 32;
    localparam int OUT_BYTES_W = 40;

    // Q8 tangents of 22.5 and 67.5 degrees
    localparam int TAN_LO_Q8 = 106;
    localparam int TAN_HI_Q8 = 618;

    // configuration register indexes
    localparam logic REG_IMAGE_WIDTH  = 1'b0;
    localparam logic REG_IMAGE_HEIGHT = 1'b1;

    // direction codes
    localparam logic [DIR_BITS-1:0] DIR_HORZ  = 2'd0;
    localparam logic [DIR_BITS-1:0] DIR_DIAG  = 2'd1;
    localparam logic [DIR_BITS-1:0] DIR_VERT  = 2'd2;
    localparam logic [DIR_BITS-1:0] DIR_ADIAG = 2'd3;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MULT,
        ST_SUM,
        ST_ROOT,
        ST_DONE
    } state_t;

    // square root request and response
    typedef struct packed {
        logic                start;
        logic [SQ_BITS-1:0]  operand;
    } sqrt_req_t;

    typedef struct packed {
        logic                done;
        logic [MAG_BITS-1:0] root;
    } sqrt_rsp_t;

    // one line-buffer entry: upper magnitude, middle magnitude, middle direction
    typedef struct packed {
        logic [MAG_BITS-1:0] upper;
        logic [MAG_BITS-1:0] middle;
        logic [DIR_BITS-1:0] dir;
    } line_entry_t;

endpackage

### rtl/canny_non_max_suppression_core.sv
// Canny non-maximum suppression over a raster stream of gradient pairs, four directions.
// Depends on cnms_pkg, cnms_line_ram and cnms_sqrt.
//
// Usage:
//   s_ channel: one word per pixel in raster order, tdata = grad_x, grad_y.
//   m_ channel: tdata = suppressed_mag, out_row, out_col; tlast marks the
//   last result of a frame (pixel height-2, width-2).
//   cfg port: write image_width (index 0) or image_height (index 1) while
//   idle; a write restarts the frame at row 0, column 0.
// Flow: each pixel passes accept and read, multiply, sum, the 16-step square
//   root unit that computes the magnitude, the root's done flag and write-back
//   (which can wait on the output, see Stall) before the next one can be
//   accepted; only one pixel is in flight at a time.
//   The result of a pixel leaves one row plus one pixel after it arrives;
//   the first width+1 words of a frame give no result, the trailing border
//   pixels are never emitted.
// Reset: counters, window and output register clear; the line store is not
//   cleared, its stale entries only feed border results.
// Stall: a finished result waits in the output register; the next pixel is
//   still accepted and processed, and only its write-back waits until the
//   pending result is taken.
module canny_non_max_suppression_core (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [15:0] grad_x, [31:16] grad_y
    input  logic [cnms_pkg::IN_BYTES_W-1:0]   s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [15:0] suppressed_mag, [26:16] out_row, [37:27] out_col, [39:38] zero
    output logic [cnms_pkg::OUT_BYTES_W-1:0]  m_tdata,
    output logic                              m_tlast,
    input  logic                              cfg_we,
    input  logic                              cfg_index,
    input  logic [cnms_pkg::DIM_BITS-1:0]     cfg_wdata
);
    import cnms_pkg::*;

    state_t state_reg, state_next;

    logic [DIM_BITS-1:0]  width_reg, height_reg;
    logic [POS_BITS-1:0]  row_reg, col_reg;
    logic [ABS_BITS-1:0]  ax_reg, ay_reg;
    logic                 same_sign_reg;
    logic [SQ_BITS-1:0]   sqx_reg, sqy_reg;
    logic [DIR_BITS-1:0]  dir_reg;
    logic [MAG_BITS-1:0]  mag_reg;
    logic [MAG_BITS-1:0]  win_reg [9];
    logic [DIR_BITS-1:0]  centre_dir_reg;
    logic                 out_valid_reg;
    logic [OUT_BYTES_W-1:0] out_data_reg;
    logic                 out_last_reg;

    logic                 accept, finish, rd_en;
    logic [GRAD_BITS-1:0] gx, gy;
    sqrt_req_t            sq_req;
    sqrt_rsp_t            sq_rsp;
    line_entry_t          rd_entry, wr_entry;
    logic [DIM_BITS-1:0]  w_eff, h_eff;
    logic [MAG_BITS-1:0]  win_new [9];
    logic                 emit, inside_img, keep;
    logic [DIM_BITS-1:0]  cr, cc;
    logic [MAG_BITS-1:0]  nb_a, nb_b, res_mag;
    logic [26:0]          t_q8, lo_q8, hi_q8;

    assign gx = s_tdata[GRAD_BITS-1:0];
    assign gy = s_tdata[2*GRAD_BITS-1:GRAD_BITS];

    // clamp frame dimensions
    always_comb begin
        w_eff = (width_reg < DIM_BITS'(3)) ? DIM_BITS'(3) :
                (width_reg > DIM_BITS'(MAX_WIDTH)) ? DIM_BITS'(MAX_WIDTH) : width_reg;
        h_eff = (height_reg < DIM_BITS'(3)) ? DIM_BITS'(3) :
                (height_reg > DIM_BITS'(MAX_HEIGHT)) ? DIM_BITS'(MAX_HEIGHT) : height_reg;
    end

    // window after this pixel's shift, and the suppression decision
    always_comb begin
        win_new[0] = win_reg[1];
        win_new[1] = win_reg[2];
        win_new[2] = rd_entry.upper;
        win_new[3] = win_reg[4];
        win_new[4] = win_reg[5];
        win_new[5] = rd_entry.middle;
        win_new[6] = win_reg[7];
        win_new[7] = win_reg[8];
        win_new[8] = mag_reg;

        emit = (row_reg >= POS_BITS'(2)) || (row_reg == POS_BITS'(1) && col_reg != '0);
        if (col_reg != '0) begin
            cr = DIM_BITS'(row_reg) - 1'b1;
            cc = DIM_BITS'(col_reg) - 1'b1;
        end else begin
            cr = DIM_BITS'(row_reg) - DIM_BITS'(2);
            cc = w_eff - 1'b1;
        end
        inside_img = (cr != '0) && (cc != '0) && (cr < h_eff - 1'b1) && (cc < w_eff - 1'b1);

        case (centre_dir_reg)
            DIR_HORZ: begin
                nb_a = win_new[3];
                nb_b = win_new[5];
            end
            DIR_DIAG: begin
                nb_a = win_new[0];
                nb_b = win_new[8];
            end
            DIR_VERT: begin
                nb_a = win_new[1];
                nb_b = win_new[7];
            end
            default: begin
                nb_a = win_new[2];
                nb_b = win_new[6];
            end
        endcase
        keep    = inside_img && (win_new[4] > nb_a) && (win_new[4] > nb_b);
        res_mag = keep ? win_new[4] : '0;
    end

    // direction quantizer operands
    always_comb begin
        t_q8  = {2'b00, ay_reg, 8'h00};
        lo_q8 = 27'(ax_reg) * 27'(TAN_LO_Q8);
        hi_q8 = 27'(ax_reg) * 27'(TAN_HI_Q8);
    end

    // sequencer
    always_comb begin
        state_next = state_reg;
        accept     = 1'b0;
        finish     = 1'b0;
        rd_en      = 1'b0;
        s_tready   = (state_reg == ST_IDLE);
        sq_req.start   = 1'b0;
        sq_req.operand = sqx_reg + sqy_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    accept     = 1'b1;
                    rd_en      = 1'b1;
                    state_next = ST_MULT;
                end
            end
            ST_MULT: begin
                state_next = ST_SUM;
            end
            ST_SUM: begin
                sq_req.start = 1'b1;
                state_next   = ST_ROOT;
            end
            ST_ROOT: begin
                if (sq_rsp.done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!emit || !out_valid_reg || m_tready) begin
                    finish     = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // configuration and position counters
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= DIM_BITS'(640);
            height_reg <= DIM_BITS'(480);
            row_reg    <= '0;
            col_reg    <= '0;
        end else if (cfg_we) begin
            case (cfg_index)
                REG_IMAGE_WIDTH:  width_reg  <= cfg_wdata;
                REG_IMAGE_HEIGHT: height_reg <= cfg_wdata;
                default: ;
            endcase
            row_reg <= '0;
            col_reg <= '0;
        end else if (finish) begin
            if (DIM_BITS'(col_reg) + 1'b1 >= w_eff) begin
                col_reg <= '0;
                row_reg <= (DIM_BITS'(row_reg) + 1'b1 >= h_eff) ? '0 : row_reg + 1'b1;
            end else begin
                col_reg <= col_reg + 1'b1;
            end
        end
    end

    // operand capture, squares, direction, magnitude
    always_ff @(posedge aclk) begin
        if (accept) begin
            ax_reg        <= gx[GRAD_BITS-1] ? ABS_BITS'(-$signed({gx[GRAD_BITS-1], gx}))
                                             : {1'b0, gx};
            ay_reg        <= gy[GRAD_BITS-1] ? ABS_BITS'(-$signed({gy[GRAD_BITS-1], gy}))
                                             : {1'b0, gy};
            same_sign_reg <= gx[GRAD_BITS-1] == gy[GRAD_BITS-1];
        end
        if (state_reg == ST_MULT) begin
            sqx_reg <= SQ_BITS'(ax_reg) * SQ_BITS'(ax_reg);
            sqy_reg <= SQ_BITS'(ay_reg) * SQ_BITS'(ay_reg);
            if (t_q8 < lo_q8) begin
                dir_reg <= DIR_HORZ;
            end else if (t_q8 >= hi_q8) begin
                dir_reg <= DIR_VERT;
            end else begin
                dir_reg <= same_sign_reg ? DIR_DIAG : DIR_ADIAG;
            end
        end
        if (state_reg == ST_ROOT && sq_rsp.done) begin
            mag_reg <= sq_rsp.root;
        end
    end

    // window and centre direction advance on write-back
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= '0;
            end
            centre_dir_reg <= DIR_HORZ;
        end else if (finish) begin
            for (int i = 0; i < 9; i++) begin
                win_reg[i] <= win_new[i];
            end
            centre_dir_reg <= rd_entry.dir;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (finish && emit) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (finish && emit) begin
            out_data_reg <= {2'b00, cc[POS_BITS-1:0], cr[POS_BITS-1:0], res_mag};
            out_last_reg <= (cr == h_eff - DIM_BITS'(2)) && (cc == w_eff - DIM_BITS'(2));
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tlast  = out_last_reg;

    // shift the line entry: middle moves up, new magnitude becomes middle
    assign wr_entry.upper  = rd_entry.middle;
    assign wr_entry.middle = mag_reg;
    assign wr_entry.dir    = dir_reg;

    cnms_line_ram u_line_ram (
        .aclk    (aclk),
        .rd_en   (rd_en),
        .rd_addr (col_reg),
        .rd_data (rd_entry),
        .wr_en   (finish),
        .wr_addr (col_reg),
        .wr_data (wr_entry)
    );

    cnms_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (sq_req),
        .rsp     (sq_rsp)
    );

    // no new word while one is in flight
    a_ready_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_tready)
        else $error("input accepted while a word is in flight");

    // root completes only while waiting for it
    a_root_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        sq_rsp.done |-> (state_reg == ST_ROOT))
        else $error("square root finished outside its wait state");

    // a new result appears only after a write-back
    a_out_source: assert property (@(posedge aclk) disable iff (!aresetn)
        (!m_tvalid ##1 m_tvalid) |-> $past(finish))
        else $error("result appeared without a write-back");

    // a pending result is never overwritten
    a_no_overwrite: assert property (@(posedge aclk) disable iff (!aresetn)
        (finish && emit) |-> (!out_valid_reg || m_tready))
        else $error("pending result overwritten");

endmodule

### rtl/cnms_line_ram.sv
// Single-port-read, single-port-write line store for both magnitude lines and directions.
// Depends on cnms_pkg.
module cnms_line_ram (
    input  logic                       aclk,
    input  logic                       rd_en,
    input  logic [cnms_pkg::ADDR_BITS-1:0] rd_addr,
    output cnms_pkg::line_entry_t      rd_data,
    input  logic                       wr_en,
    input  logic [cnms_pkg::ADDR_BITS-1:0] wr_addr,
    input  cnms_pkg::line_entry_t      wr_data
);
    import cnms_pkg::*;

    line_entry_t mem [MAX_WIDTH];
    line_entry_t rd_data_reg;

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // registered read port
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

### rtl/cnms_sqrt.sv
// Bit-serial integer square root, two operand bits per cycle.
// Depends on cnms_pkg.
module cnms_sqrt (
    input  logic                aclk,
    input  logic                aresetn,
    input  cnms_pkg::sqrt_req_t req,
    output cnms_pkg::sqrt_rsp_t rsp
);
    import cnms_pkg::*;

    localparam int REM_BITS = MAG_BITS + 4;

    logic [SQ_BITS-1:0]   op_reg;
    logic [REM_BITS-1:0]  rem_reg;
    logic [MAG_BITS-1:0]  root_reg;
    logic [STEP_BITS-1:0] cnt_reg;
    logic                 active_reg;
    logic                 done_reg;

    logic [REM_BITS-1:0]  rem_shift;
    logic [REM_BITS-1:0]  trial;
    logic                 fits;

    // one restoring step
    always_comb begin
        rem_shift = {rem_reg[REM_BITS-3:0], op_reg[SQ_BITS-1 -: 2]};
        trial     = {2'b00, root_reg, 2'b01};
        fits      = rem_shift >= trial;
    end

    // control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
            done_reg   <= 1'b0;
            cnt_reg    <= '0;
        end else begin
            done_reg <= 1'b0;
            if (req.start) begin
                active_reg <= 1'b1;
                cnt_reg    <= STEP_BITS'(ROOT_STEPS - 1);
            end else if (active_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == '0) begin
                    active_reg <= 1'b0;
                    done_reg   <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        if (req.start) begin
            op_reg   <= req.operand;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (active_reg) begin
            op_reg   <= {op_reg[SQ_BITS-3:0], 2'b00};
            rem_reg  <= fits ? (rem_shift - trial) : rem_shift;
            root_reg <= {root_reg[MAG_BITS-2:0], fits};
        end
    end

    assign rsp.done = done_reg;
    assign rsp.root = root_reg;

endmodule

### test/canny_non_max_suppression_core_tb.sv
// Testbench of canny_non_max_suppression_core: a random and directed gradient stream runs
// against a built-in model of the suppression window, and every result word is checked.
// Depends on cnms_pkg and the core RTL.
`timescale 1ns / 1ps

module canny_non_max_suppression_core_tb;
    import cnms_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int SETTLE      = 60;

    typedef struct packed {
        logic [15:0] mag;
        logic [10:0] row;
        logic [10:0] col;
        logic        last;
    } nms_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [31:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [39:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we = 1'b0;
    logic        cfg_index = REG_IMAGE_WIDTH;
    logic [11:0] cfg_wdata = '0;

    canny_non_max_suppression_core u_top (
        .aclk(aclk), .aresetn(aresetn),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // model state
    logic [11:0] width_reg = 12'd640;
    logic [11:0] height_reg = 12'd480;
    logic [15:0] upper_line [0:2047];
    logic [15:0] middle_line [0:2047];
    logic [1:0]  dir_line [0:2047];
    logic [15:0] win [0:8];
    logic [1:0]  centre_dir = DIR_HORZ;
    int unsigned row_pos = 0;
    int unsigned col_pos = 0;

    logic [31:0] pixel_q [$];
    nms_result_t expected_q [$];
    int          errors = 0;
    int          results_seen = 0;
    bit          calm = 0;

    initial begin
        for (int i = 0; i < 2048; i++) begin
            upper_line[i] = '0;
            middle_line[i] = '0;
            dir_line[i] = DIR_HORZ;
        end
        for (int i = 0; i < 9; i++) win[i] = '0;
    end

    function automatic int unsigned clamp_dim(logic [11:0] v);
        if (v < 3) return 3;
        if (v > 2048) return 2048;
        return 32'(v);
    endfunction

    function automatic logic [31:0] int_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b = b >> 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r[31:0];
    endfunction

    // Advance the window by one pixel and queue the centre result it completes.
    task automatic predict_pixel(logic signed [15:0] gx, logic signed [15:0] gy);
        int unsigned w, h, cr, cc;
        logic [16:0] ax, ay;
        logic [31:0] root;
        logic [15:0] m, up, mid, c, a, b;
        logic [63:0] t;
        logic [1:0]  d, dir_read;
        nms_result_t res;
        w = clamp_dim(width_reg);
        h = clamp_dim(height_reg);
        ax = gx[15] ? 17'(-$signed({gx[15], gx})) : {1'b0, gx};
        ay = gy[15] ? 17'(-$signed({gy[15], gy})) : {1'b0, gy};
        root = int_sqrt(64'(ax) * ax + 64'(ay) * ay);
        m = (root > 32'hFFFF) ? 16'hFFFF : root[15:0];
        t = 64'(ay) * 256;
        if (t < 64'(TAN_LO_Q8) * ax) d = DIR_HORZ;
        else if (t >= 64'(TAN_HI_Q8) * ax) d = DIR_VERT;
        else d = (gx[15] == gy[15]) ? DIR_DIAG : DIR_ADIAG;

        up = upper_line[col_pos];
        mid = middle_line[col_pos];
        dir_read = dir_line[col_pos];
        upper_line[col_pos] = mid;
        middle_line[col_pos] = m;
        dir_line[col_pos] = d;
        for (int i = 0; i < 3; i++) begin
            win[i*3] = win[i*3+1];
            win[i*3+1] = win[i*3+2];
        end
        win[2] = up;
        win[5] = mid;
        win[8] = m;

        if (row_pos >= 2 || (row_pos == 1 && col_pos >= 1)) begin
            if (col_pos >= 1) begin
                cr = row_pos - 1;
                cc = col_pos - 1;
            end else begin
                cr = row_pos - 2;
                cc = w - 1;
            end
            res = '0;
            if (cr != 0 && cc != 0 && cr < h - 1 && cc < w - 1) begin
                c = win[4];
                case (centre_dir)
                    DIR_HORZ: begin a = win[3]; b = win[5]; end
                    DIR_DIAG: begin a = win[0]; b = win[8]; end
                    DIR_VERT: begin a = win[1]; b = win[7]; end
                    default:  begin a = win[2]; b = win[6]; end
                endcase
                if (c > a && c > b) res.mag = c;
            end
            res.row = cr[10:0];
            res.col = cc[10:0];
            res.last = (cr == h - 2 && cc == w - 2);
            expected_q.push_back(res);
        end
        centre_dir = dir_read;

        col_pos++;
        if (col_pos >= w) begin
            col_pos = 0;
            row_pos++;
            if (row_pos >= h) row_pos = 0;
        end
    endtask

    // Gradient pair with a random flavor: small ties, full range, extremes, sector edges.
    function automatic logic [31:0] random_pixel();
        logic signed [15:0] gx, gy;
        int unsigned ax, ay;
        case ($urandom_range(0, 9))
            0, 1, 2: begin
                gx = 16'($signed($urandom_range(0, 16)) - 8);
                gy = 16'($signed($urandom_range(0, 16)) - 8);
            end
            3, 4: begin
                gx = 16'($urandom);
                gy = 16'($urandom);
            end
            5: begin
                gx = $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
                gy = $urandom_range(0, 2) == 0 ? 16'sh0000 :
                     ($urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF);
            end
            default: begin
                ax = $urandom_range(1, 300);
                ay = ($urandom_range(0, 1) ? ax * TAN_LO_Q8 : ax * TAN_HI_Q8) / 256;
                ay = ay + $urandom_range(0, 2);
                gx = $urandom_range(0, 1) ? -16'(ax) : 16'(ax);
                gy = $urandom_range(0, 1) ? -16'(ay) : 16'(ay);
            end
        endcase
        return {gy, gx};
    endfunction

    // driver: offer queued pixels with random idle bursts
    int gap_left = 0;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            gap_left <= 0;
        end else begin
            if (s_tvalid && s_tready) predict_pixel(s_tdata[15:0], s_tdata[31:16]);
            if (!s_tvalid || s_tready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_tvalid <= 1'b0;
                end else if (pixel_q.size() != 0 && !calm && $urandom_range(0, 5) == 0) begin
                    gap_left <= $urandom_range(0, 7);
                    s_tvalid <= 1'b0;
                end else if (pixel_q.size() != 0) begin
                    s_tdata <= pixel_q.pop_front();
                    s_tvalid <= 1'b1;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor: check each result word, stall at random, hold off once for long
    int  busy_left = 0;
    int  hold_left = 0;
    bit  held = 0;
    always @(posedge aclk) begin
        nms_result_t exp_r;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_q.size() == 0) begin
                    $error("unexpected result word: tdata %h", m_tdata);
                    errors++;
                end else begin
                    exp_r = expected_q.pop_front();
                    if (m_tdata[15:0] !== exp_r.mag) begin
                        $error("suppressed_mag expected %0d actual %0d", exp_r.mag, m_tdata[15:0]);
                        errors++;
                    end
                    if (m_tdata[26:16] !== exp_r.row) begin
                        $error("out_row expected %0d actual %0d", exp_r.row, m_tdata[26:16]);
                        errors++;
                    end
                    if (m_tdata[37:27] !== exp_r.col) begin
                        $error("out_col expected %0d actual %0d", exp_r.col, m_tdata[37:27]);
                        errors++;
                    end
                    if (m_tlast !== exp_r.last) begin
                        $error("frame_last expected %0d actual %0d", exp_r.last, m_tlast);
                        errors++;
                    end
                end
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                m_tready <= 1'b0;
            end else if (!held && results_seen >= 60) begin
                held <= 1;
                hold_left <= 600;
                m_tready <= 1'b0;
            end else if (busy_left != 0) begin
                busy_left <= busy_left - 1;
                m_tready <= 1'b0;
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                busy_left <= $urandom_range(0, 7);
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // watchdog
    int cycles = 0;
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("canny_non_max_suppression_core_tb failed");
            $finish;
        end
    end

    // Wait until the stream has drained and the core has gone quiet.
    task automatic drain();
        while (pixel_q.size() != 0 || s_tvalid || expected_q.size() != 0) @(posedge aclk);
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_reg(logic idx, logic [11:0] value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        if (idx == REG_IMAGE_WIDTH) width_reg = value;
        else height_reg = value;
        row_pos = 0;
        col_pos = 0;
    endtask

    task automatic random_phase(logic [11:0] w, logic [11:0] h, int n);
        drain();
        write_reg(REG_IMAGE_WIDTH, w);
        write_reg(REG_IMAGE_HEIGHT, h);
        for (int i = 0; i < n; i++) pixel_q.push_back(random_pixel());
    endtask

    logic [31:0] directed [0:24] = '{
        {16'sh0000, 16'sh0000}, {16'sh8000, 16'sh8000}, {16'sh7FFF, 16'sh7FFF},
        {16'sh8000, 16'sh0000}, {16'sh0000, 16'sh7FFF},
        {16'sh0005, 16'sh0003}, {16'sh0000, 16'sh0200}, {16'sh0100, 16'sh0100},
        {16'shFF00, 16'sh0100}, {16'sh7FFF, 16'sh8000},
        {16'sh0001, 16'sh0002}, {16'sh0064, 16'sh0000}, {16'sh7000, 16'sh0000},
        {16'sh0064, 16'sh0000}, {16'sh0000, 16'sh0000},
        {16'sh0029, 16'sh0064}, {16'sh0300, 16'sh0300}, {16'sh0000, 16'sh0000},
        {16'sh0300, 16'shFD00}, {16'sh00F2, 16'sh0064},
        {16'shFFFF, 16'sh0001}, {16'sh0002, 16'sh0002}, {16'sh0000, 16'sh0000},
        {16'sh8000, 16'sh7FFF}, {16'sh0001, 16'sh0000}
    };

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed frame: extremes, every direction, ties and border pixels
        write_reg(REG_IMAGE_WIDTH, 12'd5);
        write_reg(REG_IMAGE_HEIGHT, 12'd5);
        for (int i = 0; i < 25; i++) pixel_q.push_back(directed[i]);

        random_phase(12'd3, 12'd3, 40);
        random_phase(12'($urandom_range(3, 12)), 12'($urandom_range(3, 8)), 100);
        random_phase(12'd0, 12'd1, 30);
        random_phase(12'($urandom_range(3, 12)), 12'($urandom_range(3, 8)), 100);
        random_phase(12'd2, 12'd2, 20);
        random_phase(12'd4095, 12'd3, 40);
        random_phase(12'd3, 12'd4095, 60);
        random_phase(12'($urandom_range(4, 16)), 12'($urandom_range(3, 8)), 100);
        drain();
        calm = 1;
        random_phase(12'($urandom_range(3, 12)), 12'($urandom_range(3, 8)), 80);

        drain();
        if (errors == 0) begin
            $display("canny_non_max_suppression_core_tb passed");
        end else begin
            $display("canny_non_max_suppression_core_tb failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/cnms_pkg.sv
rtl/cnms_line_ram.sv
rtl/cnms_sqrt.sv
rtl/canny_non_max_suppression_core.sv
test/canny_non_max_suppression_core_tb.sv
